### rtl/qypr_pkg.sv
// shared types, constants and helpers for the quaternion to euler angle pipeline
package qypr_pkg;

  localparam int SQRT_STEPS = 15;
  localparam logic [14:0] Q14_ONE = 15'd16384;
  localparam logic [15:0] LOCK_TOL_RESET = 16'd16;

  // one cordic lane: vector, accumulated angle (full circle = 2^24), zero-vector flag
  typedef struct packed {
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic signed [25:0] z;
    logic               zero;
  } cvec_t;

  // everything one item carries down the pipe; each stage uses what it needs
  typedef struct packed {
    logic signed [31:0] pxx;
    logic signed [31:0] pyy;
    logic signed [31:0] pzz;
    logic signed [31:0] pxy;
    logic signed [31:0] pwz;
    logic signed [31:0] pyz;
    logic signed [31:0] pwx;
    logic signed [31:0] pwy;
    logic signed [31:0] pxz;
    logic signed [15:0] s;
    logic               lck;
    logic [29:0]        rem;
    logic [29:0]        res;
    cvec_t [2:0]        cv;   // 0 yaw, 1 roll, 2 pitch
    logic [15:0]        yaw;
    logic [15:0]        pitch;
    logic [15:0]        roll;
  } stage_t;

  // rounded arctangent table, full circle = 2^24
  function automatic logic signed [25:0] atan_step(input logic [4:0] k);
    logic signed [25:0] a;
    case (k)
      5'd0:  a = 26'sd2097152;
      5'd1:  a = 26'sd1238021;
      5'd2:  a = 26'sd654136;
      5'd3:  a = 26'sd332050;
      5'd4:  a = 26'sd166669;
      5'd5:  a = 26'sd83416;
      5'd6:  a = 26'sd41718;
      5'd7:  a = 26'sd20860;
      5'd8:  a = 26'sd10430;
      5'd9:  a = 26'sd5215;
      5'd10: a = 26'sd2608;
      5'd11: a = 26'sd1304;
      5'd12: a = 26'sd652;
      5'd13: a = 26'sd326;
      5'd14: a = 26'sd163;
      5'd15: a = 26'sd81;
      5'd16: a = 26'sd41;
      5'd17: a = 26'sd20;
      5'd18: a = 26'sd10;
      5'd19: a = 26'sd5;
      5'd20: a = 26'sd3;
      5'd21: a = 26'sd1;
      5'd22: a = 26'sd1;
      default: a = 26'sd0;
    endcase
    return a;
  endfunction

  // fold the left half plane onto the right one, starting at a half turn
  function automatic cvec_t cordic_pre(input cvec_t c);
    cvec_t r;
    r = c;
    r.zero = (c.x == 36'sd0) && (c.y == 36'sd0);
    r.z = 26'sd0;
    if (c.x < 36'sd0) begin
      r.x = -c.x;
      r.y = -c.y;
      r.z = 26'sd8388608;
    end
    return r;
  endfunction

endpackage

### rtl/quat_to_yaw_pitch_roll_top.sv
// quaternion to zyx euler angles, fully pipelined cordic
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  input    | in_valid / in_ready  | quat_w, quat_x, quat_y, quat_z (s16 q1.14)
//  output   | out_valid/ out_ready | yaw_angle, pitch_angle, roll_angle, gimbal_lock
//  config   | cfg_wen (no wait)    | cfg_wdata -> lock_tolerance (u15 q1.14)
//
//  one transfer per cycle in and out unless out_ready stalls; the stages are
//  products, matrix terms, sine square, 15 square root steps, quadrant fold,
//  one cordic step per stage, output format
//  every stage has a valid bit; a stage loads when it is empty or its successor moves,
//  so bubbles close up and a stall on out_ready holds every item in place
//  rst clears the valid bits and sets lock_tolerance back to 16
module quat_to_yaw_pitch_roll_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [14:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] yaw_angle,
  output logic signed [15:0] pitch_angle,
  output logic signed [15:0] roll_angle,
  output logic               gimbal_lock
);

  // steps beyond the arctangent table add nothing
  localparam int NSTEP = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int SQ0   = 3;                             // first square root stage
  localparam int PRE   = SQ0 + qypr_pkg::SQRT_STEPS;    // quadrant fold stage
  localparam int FMT   = PRE + NSTEP + 1;               // output format stage
  localparam int NST   = FMT + 1;

  logic [14:0]      lock_tolerance;
  logic [NST-1:0]   v;
  logic [NST:0]     adv;
  qypr_pkg::stage_t st [NST];
  qypr_pkg::stage_t nx [NST];

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      lock_tolerance <= 15'(qypr_pkg::LOCK_TOL_RESET);
    end else if (cfg_wen) begin
      lock_tolerance <= cfg_wdata;
    end
  end

  // a stage may load when empty or when its contents move on
  always_comb begin
    adv[NST] = out_ready;
    for (int i = NST - 1; i >= 0; i--) begin
      adv[i] = ~v[i] | adv[i+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NST; i++) begin
      if (adv[i]) begin
        st[i] <= nx[i];
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < NST; g++) begin : g_stage
      if (g == 0) begin : g_prod
        // the nine quaternion products
        always_comb begin
          nx[g] = '0;
          nx[g].pxx = quat_x * quat_x;
          nx[g].pyy = quat_y * quat_y;
          nx[g].pzz = quat_z * quat_z;
          nx[g].pxy = quat_x * quat_y;
          nx[g].pwz = quat_w * quat_z;
          nx[g].pyz = quat_y * quat_z;
          nx[g].pwx = quat_w * quat_x;
          nx[g].pwy = quat_w * quat_y;
          nx[g].pxz = quat_x * quat_z;
        end
      end else if (g == 1) begin : g_matrix
        // matrix terms in q.28 and the rounded, saturated sine of pitch
        always_comb begin : mx
          logic signed [35:0] sp;
          logic signed [21:0] sf;
          nx[g] = st[g-1];
          nx[g].cv[0].x = 36'sd268435456 - ((36'(st[g-1].pyy) + 36'(st[g-1].pzz)) <<< 1);
          nx[g].cv[0].y = (36'(st[g-1].pxy) + 36'(st[g-1].pwz)) <<< 1;
          nx[g].cv[1].x = 36'sd268435456 - ((36'(st[g-1].pxx) + 36'(st[g-1].pyy)) <<< 1);
          nx[g].cv[1].y = (36'(st[g-1].pyz) + 36'(st[g-1].pwx)) <<< 1;
          sp = (36'(st[g-1].pwy) - 36'(st[g-1].pxz)) <<< 1;
          sf = 22'((sp + 36'sd8192) >>> 14);
          if (sf > 22'sd16384) begin
            nx[g].s = 16'sd16384;
          end else if (sf < -22'sd16384) begin
            nx[g].s = -16'sd16384;
          end else begin
            nx[g].s = 16'(sf);
          end
        end
      end else if (g == 2) begin : g_square
        // radicand for the cosine and the lock test
        always_comb begin : sq
          logic signed [31:0] ss;
          logic [14:0]        abs_s;
          ss = st[g-1].s * st[g-1].s;
          abs_s = st[g-1].s[15] ? 15'(-st[g-1].s) : 15'(st[g-1].s);
          nx[g] = st[g-1];
          nx[g].rem = 30'(32'sd268435456 - ss);
          nx[g].res = '0;
          nx[g].lck = (qypr_pkg::Q14_ONE - abs_s) <= lock_tolerance;
        end
      end else if (g < PRE) begin : g_sqrt
        // one bit pair of the integer square root per stage
        localparam logic [29:0] BITV = 30'(1) << (28 - 2 * (g - SQ0));
        always_comb begin : rt
          logic [29:0] t;
          t = st[g-1].res + BITV;
          nx[g] = st[g-1];
          if (st[g-1].rem >= t) begin
            nx[g].rem = st[g-1].rem - t;
            nx[g].res = (st[g-1].res >> 1) + BITV;
          end else begin
            nx[g].res = st[g-1].res >> 1;
          end
        end
      end else if (g == PRE) begin : g_pre
        always_comb begin : pr
          qypr_pkg::cvec_t pv;
          pv = st[g-1].cv[2];
          pv.x = 36'(st[g-1].res) <<< 14;
          pv.y = 36'(st[g-1].s) <<< 14;
          nx[g] = st[g-1];
          nx[g].cv[0] = qypr_pkg::cordic_pre(st[g-1].cv[0]);
          nx[g].cv[1] = qypr_pkg::cordic_pre(st[g-1].cv[1]);
          nx[g].cv[2] = qypr_pkg::cordic_pre(pv);
        end
      end else if (g < FMT) begin : g_cordic
        // vectoring step, all three lanes side by side
        localparam int K = g - PRE - 1;
        always_comb begin : cs
          logic signed [35:0] dx;
          logic signed [35:0] dy;
          nx[g] = st[g-1];
          for (int j = 0; j < 3; j++) begin
            dx = st[g-1].cv[j].y >>> K;
            dy = st[g-1].cv[j].x >>> K;
            if (st[g-1].cv[j].y >= 36'sd0) begin
              nx[g].cv[j].x = st[g-1].cv[j].x + dx;
              nx[g].cv[j].y = st[g-1].cv[j].y - dy;
              nx[g].cv[j].z = st[g-1].cv[j].z + qypr_pkg::atan_step(5'(K));
            end else begin
              nx[g].cv[j].x = st[g-1].cv[j].x - dx;
              nx[g].cv[j].y = st[g-1].cv[j].y + dy;
              nx[g].cv[j].z = st[g-1].cv[j].z - qypr_pkg::atan_step(5'(K));
            end
          end
        end
      end else begin : g_format
        // round angles to 16 bits, clamp pitch, apply gimbal lock
        always_comb begin : fm
          logic signed [25:0] zy;
          logic signed [25:0] zr;
          logic signed [25:0] zp;
          logic signed [17:0] pt;
          zy = (st[g-1].cv[0].zero ? 26'sd0 : st[g-1].cv[0].z) + 26'sd128;
          zr = (st[g-1].cv[1].zero ? 26'sd0 : st[g-1].cv[1].z) + 26'sd128;
          zp = (st[g-1].cv[2].zero ? 26'sd0 : st[g-1].cv[2].z) + 26'sd128;
          pt = 18'(zp >>> 8);
          nx[g] = st[g-1];
          nx[g].yaw = zy[23:8];
          if (st[g-1].lck) begin
            nx[g].pitch = st[g-1].s[15] ? 16'hC000 : 16'h4000;
            nx[g].roll = 16'h0000;
          end else begin
            if (pt > 18'sd16384) begin
              nx[g].pitch = 16'h4000;
            end else if (pt < -18'sd16384) begin
              nx[g].pitch = 16'hC000;
            end else begin
              nx[g].pitch = 16'(pt);
            end
            nx[g].roll = zr[23:8];
          end
        end
      end
    end
  endgenerate

  assign out_valid   = v[FMT];
  assign yaw_angle   = st[FMT].yaw;
  assign pitch_angle = st[FMT].pitch;
  assign roll_angle  = st[FMT].roll;
  assign gimbal_lock = st[FMT].lck;

endmodule
